@@ hdl/work_stealing_task_scheduler_top_defines.svh @@
`ifndef WORK_STEALING_TASK_SCHEDULER_TOP_DEFINES_SVH
`define WORK_STEALING_TASK_SCHEDULER_TOP_DEFINES_SVH

// ----------------------------------------------------------------------------
// Assertion helpers for the work stealing task scheduler
// Immediate and next-cycle implications, both disabled while reset is low
// ----------------------------------------------------------------------------

// antecedent implies consequent in the same cycle
`define WSTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define WSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wsts_pkg.sv @@
// ----------------------------------------------------------------------------
// wsts_pkg
// Shared types and codes of the work stealing task scheduler
// ----------------------------------------------------------------------------
package wsts_pkg;

    // width of the task identifier fields on the ports
    localparam int FIELD_TASK_W = 16;

    // mode field codes
    localparam logic MODE_SUBMIT  = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // source field codes
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_OWN   = 2'd1;
    localparam logic [1:0] SRC_FIFO  = 2'd2;
    localparam logic [1:0] SRC_STEAL = 2'd3;

    // operation chosen for one transaction
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DROP,
        OP_SUB_DQ,
        OP_SUB_FIFO,
        OP_POP_OWN,
        OP_POP_FIFO,
        OP_STEAL
    } op_t;

endpackage

@@ hdl/wsts_ram.sv @@
// ----------------------------------------------------------------------------
// wsts_ram
// Simple dual-port synchronous RAM, one write and one registered read port
// ----------------------------------------------------------------------------
module wsts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/wsts_pick.sv @@
// ----------------------------------------------------------------------------
// wsts_pick
// Chooses the operation and target deque of one transaction, including the
// round-robin victim search over the non-empty flags
// ----------------------------------------------------------------------------
module wsts_pick #(
    parameter int WORKERS = 4,
    localparam int WI = $clog2(WORKERS)
) (
    input  logic               mode,
    input  logic               is_worker,
    input  logic [1:0]         worker,
    input  logic [WORKERS-1:0] nonempty,
    input  logic [WORKERS-1:0] full,
    input  logic               fifo_empty,
    input  logic               fifo_full,
    output wsts_pkg::op_t      op,
    output logic [WI-1:0]      tgt
);

    localparam int WI1 = WI + 1;

    logic [1:0]           wk_mod;
    logic [WI-1:0]        w;
    logic [WI:0]          shamt;
    logic [2*WORKERS-1:0] dbl;
    logic [2*WORKERS-1:0] shifted;
    logic [WORKERS-1:0]   rot;
    logic [WI-1:0]        idx;
    logic                 found;
    logic [WI:0]          vsum;
    logic [WI-1:0]        vic;

    always_comb
    begin
        // worker index taken modulo the pool size
        wk_mod = (int'(worker) >= WORKERS) ? (worker - 2'(WORKERS)) : worker;
        w      = WI'(wk_mod);

        // rotate so that bit i is deque w+1+i
        shamt   = WI1'(w) + WI1'(1);
        dbl     = {nonempty, nonempty};
        shifted = dbl >> shamt;
        rot     = shifted[WORKERS-1:0];

        idx   = '0;
        found = 1'b0;
        for (int i = WORKERS - 1; i >= 0; i--)
        begin
            if (rot[i])
            begin
                idx   = WI'(i);
                found = 1'b1;
            end
        end

        vsum = WI1'(w) + WI1'(idx) + WI1'(1);
        if (vsum >= WI1'(WORKERS))
        begin
            vsum = vsum - WI1'(WORKERS);
        end
        vic = vsum[WI-1:0];

        op  = wsts_pkg::OP_NONE;
        tgt = w;
        if (mode == wsts_pkg::MODE_SUBMIT)
        begin
            if (is_worker)
            begin
                op = full[w] ? wsts_pkg::OP_DROP : wsts_pkg::OP_SUB_DQ;
            end
            else
            begin
                op = fifo_full ? wsts_pkg::OP_DROP : wsts_pkg::OP_SUB_FIFO;
            end
        end
        else if (is_worker && nonempty[w])
        begin
            op = wsts_pkg::OP_POP_OWN;
        end
        else if (!fifo_empty)
        begin
            op = wsts_pkg::OP_POP_FIFO;
        end
        else if (found)
        begin
            op  = wsts_pkg::OP_STEAL;
            tgt = vic;
        end
    end

endmodule

@@ hdl/work_stealing_task_scheduler_top.sv @@
// path: descriptor read on accept, task store read or write in S_META, result into the
//   output register in S_DATA once the output slot is free; a new transaction can
//   be accepted in S_DATA as that result loads, never during S_META
// reset: flags, fifo pointers, fifo count and handshake state clear at once;
//   the task store and descriptor memory are not cleared and need no sweep
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler_top
// Per-worker task deques with a shared fifo for external submits; worker requests pop
// their own deque front, then the fifo head, then steal the back of a non-empty deque
// ----------------------------------------------------------------------------
`include "work_stealing_task_scheduler_top_defines.svh"

module work_stealing_task_scheduler_top #(
    parameter int WORKERS     = 4,
    parameter int DEQUE_DEPTH = 16,
    parameter int FIFO_DEPTH  = 16,
    parameter int TASK_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        is_worker,
    input  logic [1:0]  worker,
    input  logic [15:0] task_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        got_task,
    output logic [15:0] task_out,
    output logic [1:0]  source,
    output logic [1:0]  victim,
    output logic        dropped
);

    localparam int TW         = wsts_pkg::FIELD_TASK_W;
    localparam int WI         = $clog2(WORKERS);
    localparam int HW         = $clog2(DEQUE_DEPTH);
    localparam int CW         = $clog2(DEQUE_DEPTH + 1);
    localparam int CW1        = CW + 1;
    localparam int FPW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);
    localparam int SW         = (TASK_BITS < TW) ? TASK_BITS : TW;
    localparam int DQ_ENTRIES = WORKERS * DEQUE_DEPTH;
    localparam int MEM_DEPTH  = DQ_ENTRIES + FIFO_DEPTH;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int MW         = HW + CW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_META = 3'b010,
        S_DATA = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic in_accept;
    logic slot_free;
    logic out_load;

    wsts_pkg::op_t pick_op;
    logic [WI-1:0] pick_tgt;

    wsts_pkg::op_t op_reg;
    logic [WI-1:0] tgt_reg;
    logic [SW-1:0] task_reg;

    logic [WORKERS-1:0] nonempty_reg, nonempty_next;
    logic [WORKERS-1:0] full_reg, full_next;
    logic [WORKERS-1:0] meta_valid_reg, meta_valid_next;

    logic [FPW-1:0] fifo_rd_ptr_reg, fifo_rd_ptr_next;
    logic [FPW-1:0] fifo_wr_ptr_reg, fifo_wr_ptr_next;
    logic [FCW-1:0] fifo_count_reg, fifo_count_next;

    logic [MW-1:0] meta_rd;
    logic [HW-1:0] h, h_dec, h_inc, pos_back, new_h;
    logic [CW-1:0] c, new_c;
    logic [CW:0]   hc;
    logic          meta_we;

    logic [AW-1:0] base;
    logic [AW-1:0] dm_addr;
    logic          dm_we, dm_re;
    logic [SW-1:0] dm_rd;

    logic       res_got_next, res_mem_next, res_drop_next;
    logic [1:0] res_src_next, res_vic_next;
    logic       res_got_reg, res_mem_reg, res_drop_reg;
    logic [1:0] res_src_reg, res_vic_reg;

    logic        out_valid_reg;
    logic        out_got_reg, out_drop_reg;
    logic [TW-1:0] out_task_reg;
    logic [1:0]  out_src_reg, out_vic_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_DATA) && slot_free);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == S_DATA) && slot_free;

    wsts_pick #(
        .WORKERS (WORKERS)
    ) u_pick (
        .mode       (mode),
        .is_worker  (is_worker),
        .worker     (worker),
        .nonempty   (nonempty_reg),
        .full       (full_reg),
        .fifo_empty (fifo_count_reg == '0),
        .fifo_full  (fifo_count_reg == FCW'(FIFO_DEPTH)),
        .op         (pick_op),
        .tgt        (pick_tgt)
    );

    // head and count of each deque
    wsts_ram #(
        .DEPTH (WORKERS),
        .WIDTH (MW)
    ) u_meta_mem (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (tgt_reg),
        .wr_data ({new_h, new_c}),
        .rd_en   (in_accept),
        .rd_addr (pick_tgt),
        .rd_data (meta_rd)
    );

    // deque rings first, shared fifo ring after them
    wsts_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (SW)
    ) u_task_mem (
        .clk     (clk),
        .wr_en   (dm_we),
        .wr_addr (dm_addr),
        .wr_data (task_reg),
        .rd_en   (dm_re),
        .rd_addr (dm_addr),
        .rd_data (dm_rd)
    );

    // descriptor of a deque never written reads as empty with head zero
    always_comb
    begin
        h = meta_valid_reg[tgt_reg] ? meta_rd[MW-1:CW] : '0;
        c = meta_valid_reg[tgt_reg] ? meta_rd[CW-1:0]  : '0;

        h_dec = (h == '0) ? HW'(DEQUE_DEPTH - 1) : (h - HW'(1));
        h_inc = (h == HW'(DEQUE_DEPTH - 1)) ? '0 : (h + HW'(1));

        hc = CW1'(h) + CW1'(c) - CW1'(1);
        if (hc >= CW1'(DEQUE_DEPTH))
        begin
            hc = hc - CW1'(DEQUE_DEPTH);
        end
        pos_back = hc[HW-1:0];

        base = AW'(tgt_reg) * AW'(DEQUE_DEPTH);
    end

    always_comb
    begin
        meta_we          = 1'b0;
        dm_we            = 1'b0;
        dm_re            = 1'b0;
        dm_addr          = base + AW'(h);
        new_h            = h;
        new_c            = c;
        nonempty_next    = nonempty_reg;
        full_next        = full_reg;
        meta_valid_next  = meta_valid_reg;
        fifo_rd_ptr_next = fifo_rd_ptr_reg;
        fifo_wr_ptr_next = fifo_wr_ptr_reg;
        fifo_count_next  = fifo_count_reg;
        res_got_next     = 1'b0;
        res_mem_next     = 1'b0;
        res_drop_next    = 1'b0;
        res_src_next     = wsts_pkg::SRC_NONE;
        res_vic_next     = 2'd0;

        if (state_reg == S_META)
        begin
            case (op_reg)
                wsts_pkg::OP_SUB_DQ:
                begin
                    new_h   = h_dec;
                    new_c   = c + CW'(1);
                    meta_we = 1'b1;
                    dm_we   = 1'b1;
                    dm_addr = base + AW'(h_dec);
                end
                wsts_pkg::OP_POP_OWN:
                begin
                    new_h        = h_inc;
                    new_c        = c - CW'(1);
                    meta_we      = 1'b1;
                    dm_re        = 1'b1;
                    dm_addr      = base + AW'(h);
                    res_got_next = 1'b1;
                    res_mem_next = 1'b1;
                    res_src_next = wsts_pkg::SRC_OWN;
                end
                wsts_pkg::OP_STEAL:
                begin
                    new_c        = c - CW'(1);
                    meta_we      = 1'b1;
                    dm_re        = 1'b1;
                    dm_addr      = base + AW'(pos_back);
                    res_got_next = 1'b1;
                    res_mem_next = 1'b1;
                    res_src_next = wsts_pkg::SRC_STEAL;
                    res_vic_next = 2'(tgt_reg);
                end
                wsts_pkg::OP_SUB_FIFO:
                begin
                    dm_we            = 1'b1;
                    dm_addr          = AW'(DQ_ENTRIES) + AW'(fifo_wr_ptr_reg);
                    fifo_wr_ptr_next = (fifo_wr_ptr_reg == FPW'(FIFO_DEPTH - 1)) ?
                                       '0 : (fifo_wr_ptr_reg + FPW'(1));
                    fifo_count_next  = fifo_count_reg + FCW'(1);
                end
                wsts_pkg::OP_POP_FIFO:
                begin
                    dm_re            = 1'b1;
                    dm_addr          = AW'(DQ_ENTRIES) + AW'(fifo_rd_ptr_reg);
                    fifo_rd_ptr_next = (fifo_rd_ptr_reg == FPW'(FIFO_DEPTH - 1)) ?
                                       '0 : (fifo_rd_ptr_reg + FPW'(1));
                    fifo_count_next  = fifo_count_reg - FCW'(1);
                    res_got_next     = 1'b1;
                    res_mem_next     = 1'b1;
                    res_src_next     = wsts_pkg::SRC_FIFO;
                end
                wsts_pkg::OP_DROP:
                begin
                    res_drop_next = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (meta_we)
            begin
                nonempty_next[tgt_reg]   = (new_c != '0);
                full_next[tgt_reg]       = (new_c == CW'(DEQUE_DEPTH));
                meta_valid_next[tgt_reg] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (in_accept)
                begin
                    state_next = S_META;
                end
                else if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            nonempty_reg    <= '0;
            full_reg        <= '0;
            meta_valid_reg  <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_wr_ptr_reg <= '0;
            fifo_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            nonempty_reg    <= nonempty_next;
            full_reg        <= full_next;
            meta_valid_reg  <= meta_valid_next;
            fifo_rd_ptr_reg <= fifo_rd_ptr_next;
            fifo_wr_ptr_reg <= fifo_wr_ptr_next;
            fifo_count_reg  <= fifo_count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= pick_op;
            tgt_reg  <= pick_tgt;
            task_reg <= task_id[SW-1:0];
        end
        if (state_reg == S_META)
        begin
            res_got_reg  <= res_got_next;
            res_mem_reg  <= res_mem_next;
            res_drop_reg <= res_drop_next;
            res_src_reg  <= res_src_next;
            res_vic_reg  <= res_vic_next;
        end
        if (out_load)
        begin
            out_got_reg  <= res_got_reg;
            out_task_reg <= res_mem_reg ? TW'(dm_rd) : '0;
            out_src_reg  <= res_src_reg;
            out_vic_reg  <= res_vic_reg;
            out_drop_reg <= res_drop_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign got_task  = out_got_reg;
    assign task_out  = out_task_reg;
    assign source    = out_src_reg;
    assign victim    = out_vic_reg;
    assign dropped   = out_drop_reg;

    `WSTS_ASSERT_SAME(a_no_accept_in_meta, clk, rst_n, state_reg == S_META, !in_ready, "transaction accepted during descriptor read")
    `WSTS_ASSERT_NEXT(a_overlap_goes_meta, clk, rst_n, (state_reg == S_DATA) && in_accept, state_reg == S_META, "overlapped transaction lost")
    `WSTS_ASSERT_SAME(a_nonempty_has_desc, clk, rst_n, 1'b1, (nonempty_reg & ~meta_valid_reg) == '0, "non-empty deque without descriptor")
    `WSTS_ASSERT_SAME(a_full_is_nonempty, clk, rst_n, 1'b1, (full_reg & ~nonempty_reg) == '0, "full deque flagged empty")
    `WSTS_ASSERT_SAME(a_served_has_source, clk, rst_n, out_valid_reg && out_got_reg, out_src_reg != wsts_pkg::SRC_NONE, "served request without source")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the work stealing task scheduler against a cycle-free predictor of its
// deques and shared fifo; random bursts on the input side, random stalls and one
// long hold-off on the output side, results compared field by field in order
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_WORKERS = 4;
    localparam int DQ_DEPTH    = 16;
    localparam int SHARED_DEPTH = 16;
    localparam int RANDOM_ITEMS = 1300;
    localparam int ITEM_SLOTS   = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_START   = 1000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic        mode;
        logic        is_worker;
        logic [1:0]  worker;
        logic [15:0] task_id;
    } sched_item_t;

    typedef struct {
        logic        got_task;
        logic [15:0] task_out;
        logic [1:0]  source;
        logic [1:0]  victim;
        logic        dropped;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic        is_worker = 1'b0;
    logic [1:0]  worker = 2'd0;
    logic [15:0] task_id = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        got_task;
    logic [15:0] task_out;
    logic [1:0]  source;
    logic [1:0]  victim;
    logic        dropped;

    // pending stimulus and expected results, each with its own read and write index
    sched_item_t   pending_items [ITEM_SLOTS];
    sched_result_t expected_results [ITEM_SLOTS];
    int            pend_wr = 0;
    int            pend_rd = 0;
    int            exp_wr = 0;
    int            exp_rd = 0;
    int            received_count = 0;
    sched_item_t   item_on_bus;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    // predictor copy of the queues
    logic [15:0] dq_mem [NUM_WORKERS][DQ_DEPTH];
    logic [3:0]  dq_head [NUM_WORKERS];
    logic [4:0]  dq_count [NUM_WORKERS];
    logic [15:0] shared_mem [SHARED_DEPTH];
    logic [3:0]  shared_rd;
    logic [3:0]  shared_wr;
    logic [4:0]  shared_count;

    work_stealing_task_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .is_worker (is_worker),
        .worker    (worker),
        .task_id   (task_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .got_task  (got_task),
        .task_out  (task_out),
        .source    (source),
        .victim    (victim),
        .dropped   (dropped)
    );

    always #6 clk = ~clk;

    function automatic sched_item_t make_item(logic m, logic wk, logic [1:0] w,
                                              logic [15:0] t);
        sched_item_t it;
        it.mode      = m;
        it.is_worker = wk;
        it.worker    = w;
        it.task_id   = t;
        return it;
    endfunction

    task automatic add_item(logic m, logic wk, logic [1:0] w, logic [15:0] t);
        pending_items[pend_wr] = make_item(m, wk, w, t);
        pend_wr++;
    endtask

    // applies one transaction to the predicted queues and returns its result
    function automatic sched_result_t schedule_step(sched_item_t it);
        sched_result_t r;
        logic [1:0]    w;
        logic [1:0]    v;
        logic [3:0]    back;
        logic          found;
        r = '{1'b0, 16'd0, wsts_pkg::SRC_NONE, 2'd0, 1'b0};
        w = it.worker;
        found = 1'b0;
        if (it.mode == wsts_pkg::MODE_SUBMIT)
        begin
            if (it.is_worker)
            begin
                if (dq_count[w] >= DQ_DEPTH)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    dq_head[w] = dq_head[w] - 4'd1;
                    dq_mem[w][dq_head[w]] = it.task_id;
                    dq_count[w] = dq_count[w] + 5'd1;
                end
            end
            else
            begin
                if (shared_count >= SHARED_DEPTH)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    shared_mem[shared_wr] = it.task_id;
                    shared_wr = shared_wr + 4'd1;
                    shared_count = shared_count + 5'd1;
                end
            end
        end
        else if (it.is_worker && dq_count[w] > 0)
        begin
            r.task_out = dq_mem[w][dq_head[w]];
            dq_head[w] = dq_head[w] + 4'd1;
            dq_count[w] = dq_count[w] - 5'd1;
            r.got_task = 1'b1;
            r.source = wsts_pkg::SRC_OWN;
        end
        else if (shared_count > 0)
        begin
            r.task_out = shared_mem[shared_rd];
            shared_rd = shared_rd + 4'd1;
            shared_count = shared_count - 5'd1;
            r.got_task = 1'b1;
            r.source = wsts_pkg::SRC_FIFO;
        end
        else
        begin
            // scan from the next worker round-robin, own deque last
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                v = w + 2'(i) + 2'd1;
                if (!found && dq_count[v] > 0)
                begin
                    back = dq_head[v] + 4'(dq_count[v] - 5'd1);
                    r.task_out = dq_mem[v][back];
                    dq_count[v] = dq_count[v] - 5'd1;
                    r.got_task = 1'b1;
                    r.source = wsts_pkg::SRC_STEAL;
                    r.victim = v;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // input driver: bursts of transactions with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        sched_item_t nxt;
        if (in_valid && in_ready)
        begin
            expected_results[exp_wr] = schedule_step(item_on_bus);
            exp_wr++;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
                burst_left = $urandom_range(1, 40);
            end
        end
        if (!(in_valid && !in_ready))
        begin
            if (rst_n && gap_left == 0 && pend_rd < pend_wr)
            begin
                nxt = pending_items[pend_rd];
                pend_rd++;
                item_on_bus = nxt;
                in_valid  <= 1'b1;
                mode      <= nxt.mode;
                is_worker <= nxt.is_worker;
                worker    <= nxt.worker;
                task_id   <= nxt.task_id;
            end
            else
            begin
                in_valid <= 1'b0;
                if (rst_n && gap_left > 0)
                    gap_left--;
            end
        end
    end

    // output side: changing stall patterns plus one long hold-off
    int rx_cycles = 0;
    int hold_left = 0;
    int pattern_left = 0;
    int pattern_kind = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles++;
            if (rx_cycles == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (pattern_left == 0)
            begin
                pattern_kind = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 150);
            end
            else
            begin
                pattern_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (pattern_kind)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // monitor: each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            received_count++;
            if (exp_rd == exp_wr)
            begin
                $error("result transaction with no expected result pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_results[exp_rd];
                exp_rd++;
                check_field("got_task", want.got_task, got_task);
                check_field("task_out", want.task_out, task_out);
                check_field("source", want.source, source);
                check_field("victim", want.victim, victim);
                check_field("dropped", want.dropped, dropped);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int          made;
        int          seg_kind;
        int          seg_len;
        int          submit_pct;
        int          worker_pct;
        logic [1:0]  fav;
        logic        m;
        logic        wk;
        logic [1:0]  w;

        for (int i = 0; i < NUM_WORKERS; i++)
        begin
            dq_head[i] = 4'd0;
            dq_count[i] = 5'd0;
        end
        shared_rd = 4'd0;
        shared_wr = 4'd0;
        shared_count = 5'd0;

        // directed: empty requests, field extremes, own pop, fifo pop, steals
        add_item(wsts_pkg::MODE_REQUEST, 1'b1, 2'd0, 16'hFFFF);
        add_item(wsts_pkg::MODE_REQUEST, 1'b0, 2'd3, 16'h0000);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b0, 2'd0, 16'h0000);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b0, 2'd3, 16'hFFFF);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b1, 2'd0, 16'hA5A5);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b1, 2'd0, 16'h5A5A);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b1, 2'd3, 16'hFFFF);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b1, 2'd1, 16'h0001);
        add_item(wsts_pkg::MODE_REQUEST, 1'b1, 2'd0, 16'h1234);
        add_item(wsts_pkg::MODE_REQUEST, 1'b1, 2'd2, 16'h0000);
        add_item(wsts_pkg::MODE_REQUEST, 1'b0, 2'd1, 16'h0000);
        add_item(wsts_pkg::MODE_REQUEST, 1'b1, 2'd2, 16'h0000);
        add_item(wsts_pkg::MODE_REQUEST, 1'b0, 2'd3, 16'h0000);
        add_item(wsts_pkg::MODE_REQUEST, 1'b1, 2'd0, 16'h0000);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b1, 2'd2, 16'h8000);
        // external request finds only its own index non-empty
        add_item(wsts_pkg::MODE_REQUEST, 1'b0, 2'd2, 16'hFFFF);
        add_item(wsts_pkg::MODE_SUBMIT,  1'b0, 2'd1, 16'h7FFF);
        add_item(wsts_pkg::MODE_REQUEST, 1'b1, 2'd1, 16'h0000);
        add_item(wsts_pkg::MODE_REQUEST, 1'b1, 2'd3, 16'h0000);

        // random segments: balanced, fill one deque, fill the fifo, drain
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            seg_kind = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 80);
            fav = 2'($urandom_range(0, 3));
            case (seg_kind)
                0:
                begin
                    submit_pct = 50;
                    worker_pct = 60;
                end
                1:
                begin
                    submit_pct = 90;
                    worker_pct = 90;
                end
                2:
                begin
                    submit_pct = 90;
                    worker_pct = 10;
                end
                default:
                begin
                    submit_pct = 15;
                    worker_pct = 70;
                end
            endcase
            for (int k = 0; k < seg_len; k++)
            begin
                m  = ($urandom_range(0, 99) < submit_pct) ?
                     wsts_pkg::MODE_SUBMIT : wsts_pkg::MODE_REQUEST;
                wk = ($urandom_range(0, 99) < worker_pct);
                w  = ($urandom_range(0, 99) < 70) ? fav : 2'($urandom_range(0, 3));
                add_item(m, wk, w, 16'($urandom()));
                made++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (received_count < pend_wr)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
